@@ hdl/bfm3_pkg.sv @@
// shared types and constants for the bloom filter core
package bfm3_pkg;

    localparam logic [1:0]  MODE_ADD        = 2'd0;
    localparam logic [1:0]  MODE_CHECK      = 2'd1;

    localparam logic        CFG_NUM_HASHES  = 1'b0;
    localparam logic        CFG_FILTER_BITS = 1'b1;

    localparam int          ROW_BITS        = 32;

    localparam logic [31:0] MIX_C1          = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2          = 32'h1b873593;
    localparam logic [31:0] MIX_ADD         = 32'he6546b64;
    localparam logic [31:0] FMIX_C1         = 32'h85ebca6b;
    localparam logic [31:0] FMIX_C2         = 32'hc2b2ae35;

    localparam logic [4:0]  NUM_HASHES_RST  = 5'd7;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic mix1;
        logic mix2;
        logic absorb;
        logic fin_init;
        logic fin0;
        logic fin1;
        logic div_load;
        logic div_step;
        logic wr_bit;
        logic next_hash;
        logic sweep;
        logic clear_regs;
        logic finish;
        logic emit_clear;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic start_clear;
        logic last_word;
        logic key_empty;
        logic div_done;
        logic hash_last;
        logic sweep_last;
    } t_status;

endpackage

@@ hdl/bfm3_ram.sv @@
// generic single write port ram with registered read
module bfm3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hdl/bfm3_ctrl.sv @@
// controller state machine for the bloom filter core
module bfm3_ctrl
    import bfm3_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_MIX1, S_MIX2, S_ABSORB, S_CHK,
        S_FIN0, S_FIN1, S_FIN2, S_DIV, S_RD, S_WR, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_clr, n_clr;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_clr   = r_clr;
        case (r_state)
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    o_cmd.emit_clear = r_clr;
                    n_clr            = 1'b0;
                    n_state          = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_status.start_clear) begin
                        o_cmd.clear_regs = 1'b1;
                        n_clr            = 1'b1;
                        n_state          = S_SWEEP;
                    end else begin
                        o_cmd.latch = 1'b1;
                        n_state     = S_MIX1;
                    end
                end
            end
            S_MIX1: begin
                o_cmd.mix1 = 1'b1;
                n_state    = S_MIX2;
            end
            S_MIX2: begin
                o_cmd.mix2 = 1'b1;
                n_state    = S_ABSORB;
            end
            S_ABSORB: begin
                o_cmd.absorb = 1'b1;
                n_state      = i_status.last_word ? S_CHK : S_IDLE;
            end
            S_CHK: begin
                o_cmd.fin_init = 1'b1;
                n_state        = i_status.key_empty ? S_DONE : S_FIN0;
            end
            S_FIN0: begin
                o_cmd.fin0 = 1'b1;
                n_state    = S_FIN1;
            end
            S_FIN1: begin
                o_cmd.fin1 = 1'b1;
                n_state    = S_FIN2;
            end
            S_FIN2: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.wr_bit = 1'b1;
                if (i_status.hash_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.next_hash = 1'b1;
                    n_state         = S_FIN0;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_clr   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ hdl/bfm3_dp.sv @@
// datapath: hash lanes, finalizer, modulo unit, bit store and counters
module bfm3_dp
    import bfm3_pkg::*;
#(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_HASHES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_key_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        o_done,
    output logic        o_maybe_present,
    output logic [31:0] o_items_added,
    output logic [16:0] o_bits_set_count
);

    localparam int ROWS = (MAX_BITS + ROW_BITS - 1) / ROW_BITS;
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MW   = $clog2(MAX_BITS + 1);
    localparam int RW   = $clog2(MAX_BITS);
    localparam int HW   = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int NW   = $clog2(MAX_HASHES + 1);

    logic [4:0]    r_num_hashes;
    logic [16:0]   r_filter_bits;
    logic [NW-1:0] nh;
    logic [MW-1:0] mod_m;

    logic [1:0]    r_mode;
    logic [31:0]   r_word;
    logic [2:0]    r_count;
    logic          r_last;
    logic [31:0]   r_k;
    logic [31:0]   r_lane [MAX_HASHES];
    logic [31:0]   r_keylen;
    logic [31:0]   r_f;
    logic [31:0]   r_q;
    logic [RW-1:0] r_rem;
    logic [4:0]    r_dcnt;
    logic [HW-1:0] r_hidx;
    logic          r_present;
    logic [31:0]   r_items;
    logic [16:0]   r_bits;
    logic [AW-1:0] r_swp;

    logic          full_blk;
    logic [31:0]   masked;
    logic [31:0]   k_rot;
    logic [31:0]   f0;
    logic [31:0]   f1;
    logic [RW:0]   div_t;
    logic [RW:0]   div_m;
    logic [31:0]   pos;
    logic [AW-1:0] row_addr;
    logic [31:0]   row_mask;
    logic [31:0]   rdata;
    logic          bit_hit;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          do_set;

    // saturate config into legal ranges
    always_comb begin
        if (r_num_hashes == 5'd0) begin
            nh = NW'(1);
        end else if (32'(r_num_hashes) > 32'(MAX_HASHES)) begin
            nh = NW'(MAX_HASHES);
        end else begin
            nh = NW'(r_num_hashes);
        end
        if (r_filter_bits < 17'd8) begin
            mod_m = MW'(8);
        end else if (32'(r_filter_bits) > 32'(MAX_BITS)) begin
            mod_m = MW'(MAX_BITS);
        end else begin
            mod_m = MW'(r_filter_bits);
        end
    end

    assign full_blk = !r_last || (r_count >= 3'd4);

    always_comb begin
        case (r_count)
            3'd1:    masked = r_word & 32'h0000_00ff;
            3'd2:    masked = r_word & 32'h0000_ffff;
            3'd3:    masked = r_word & 32'h00ff_ffff;
            default: masked = r_word;
        endcase
        if (full_blk) begin
            masked = r_word;
        end
    end

    assign k_rot = {r_k[16:0], r_k[31:17]};
    assign f0    = r_lane[r_hidx] ^ r_keylen;
    assign f1    = r_f ^ (r_f >> 13);

    assign div_t = {r_rem, r_q[31]};
    assign div_m = (RW + 1)'(mod_m);

    assign pos      = 32'(r_rem);
    assign row_addr = pos[5 +: AW];
    assign row_mask = 32'd1 << pos[4:0];
    assign bit_hit  = |(rdata & row_mask);
    assign do_set   = i_cmd.wr_bit && (r_mode == MODE_ADD) && !bit_hit;

    assign ram_we    = i_cmd.sweep || do_set;
    assign ram_waddr = i_cmd.sweep ? r_swp : row_addr;
    assign ram_wdata = i_cmd.sweep ? 32'd0 : (rdata | row_mask);

    bfm3_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (row_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_hashes  <= NUM_HASHES_RST;
            r_filter_bits <= 17'h10000;
            r_keylen      <= '0;
            r_items       <= '0;
            r_bits        <= '0;
            r_swp         <= '0;
            r_hidx        <= '0;
            r_dcnt        <= '0;
            r_present     <= 1'b0;
            o_done        <= 1'b0;
            for (int i = 0; i < MAX_HASHES; i++) begin
                r_lane[i] <= 32'(i);
            end
        end else begin
            o_done <= i_cmd.emit_clear || i_cmd.finish;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_NUM_HASHES:  r_num_hashes  <= i_cfg_data[4:0];
                    CFG_FILTER_BITS: r_filter_bits <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.latch) begin
                r_mode  <= i_mode;
                r_word  <= i_key_word;
                r_count <= i_byte_count;
                r_last  <= i_last_word;
            end
            if (i_cmd.mix1) begin
                r_k <= masked * MIX_C1;
            end
            if (i_cmd.mix2) begin
                r_k <= k_rot * MIX_C2;
            end
            if (i_cmd.absorb) begin
                if (full_blk) begin
                    for (int i = 0; i < MAX_HASHES; i++) begin
                        logic [31:0] h;
                        h = r_lane[i] ^ r_k;
                        h = {h[18:0], h[31:19]};
                        r_lane[i] <= (h << 2) + h + MIX_ADD;
                    end
                    r_keylen <= r_keylen + 32'd4;
                end else if (r_count != 3'd0) begin
                    for (int i = 0; i < MAX_HASHES; i++) begin
                        r_lane[i] <= r_lane[i] ^ r_k;
                    end
                    r_keylen <= r_keylen + 32'(r_count);
                end
            end
            if (i_cmd.fin_init) begin
                r_hidx    <= '0;
                r_present <= (r_mode == MODE_CHECK) && (r_keylen != 32'd0);
            end
            if (i_cmd.fin0) begin
                r_f <= (f0 ^ (f0 >> 16)) * FMIX_C1;
            end
            if (i_cmd.fin1) begin
                r_f <= f1 * FMIX_C2;
            end
            if (i_cmd.div_load) begin
                r_q    <= r_f ^ (r_f >> 16);
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            // restoring division, one quotient bit a cycle
            if (i_cmd.div_step) begin
                if (div_t >= div_m) begin
                    r_rem <= RW'(div_t - div_m);
                end else begin
                    r_rem <= RW'(div_t);
                end
                r_q    <= r_q << 1;
                r_dcnt <= r_dcnt + 5'd1;
            end
            if (do_set) begin
                r_bits <= r_bits + 17'd1;
            end
            if (i_cmd.wr_bit && (r_mode == MODE_CHECK) && !bit_hit) begin
                r_present <= 1'b0;
            end
            if (i_cmd.next_hash) begin
                r_hidx <= r_hidx + HW'(1);
            end
            if (i_cmd.sweep) begin
                r_swp <= r_swp + AW'(1);
            end
            if (i_cmd.clear_regs) begin
                r_items   <= '0;
                r_bits    <= '0;
                r_swp     <= '0;
                r_keylen  <= '0;
                r_present <= 1'b0;
                for (int i = 0; i < MAX_HASHES; i++) begin
                    r_lane[i] <= 32'(i);
                end
            end
            if (i_cmd.emit_clear) begin
                o_maybe_present  <= 1'b0;
                o_items_added    <= '0;
                o_bits_set_count <= '0;
            end
            if (i_cmd.finish) begin
                o_maybe_present  <= r_present;
                o_bits_set_count <= r_bits;
                if ((r_keylen != 32'd0) && (r_mode == MODE_ADD)) begin
                    r_items       <= r_items + 32'd1;
                    o_items_added <= r_items + 32'd1;
                end else begin
                    o_items_added <= r_items;
                end
                r_keylen <= '0;
                for (int i = 0; i < MAX_HASHES; i++) begin
                    r_lane[i] <= 32'(i);
                end
            end
        end
    end

    always_comb begin
        o_status.start_clear = i_mode[1];
        o_status.last_word   = r_last;
        o_status.key_empty   = (r_keylen == 32'd0);
        o_status.div_done    = (r_dcnt == 5'd31);
        o_status.hash_last   = ((NW'(r_hidx) + NW'(1)) == nh);
        o_status.sweep_last  = (r_swp == AW'(ROWS - 1));
    end

endmodule

@@ hdl/bloom_filter_murmur3_core.sv @@
// top level of the bloom filter core with murmur3 hashing
//
// command channel: drive i_mode, i_key_word, i_byte_count, i_last_word and
// raise i_start; a word is taken at a clock edge with i_start high and o_busy
// low. keys arrive as little-endian words, the last one flagged.
// result channel: o_done pulses for one cycle with o_maybe_present,
// o_items_added and o_bits_set_count; the receiver cannot stall it, so it
// must take the word in that cycle. one result per last word and per clear.
// config channel: i_cfg_valid with i_cfg_index and i_cfg_data, always ready;
// write only while the core is idle.
// sequence: a word that is not last passes two multiplier stages for the key
// mix and one lane update before the core is back in idle and ready again.
// a last word adds, per hash, two finalizer multiplies, a 32-step
// restoring modulo unit and a read-modify-write of one store row.
// clear sweeps the bit store one 32-bit row a cycle, then pulses the
// all-zero result.
// reset: the same sweep runs right after reset (busy high, no result).
module bloom_filter_murmur3_core
    import bfm3_pkg::*;
#(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_HASHES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_key_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    // result channel
    output logic        o_done,
    output logic        o_maybe_present,
    output logic [31:0] o_items_added,
    output logic [16:0] o_bits_set_count,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // config registers are plain flops, never back-pressured
    assign o_cfg_ready = 1'b1;

    // sequencing of mix, absorb, finalize, modulo and store access
    bfm3_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    // hash lanes, modulo unit, bit store and counters
    bfm3_dp #(
        .MAX_BITS   (MAX_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_valid      (i_cfg_valid & o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_mode           (i_mode),
        .i_key_word       (i_key_word),
        .i_byte_count     (i_byte_count),
        .i_last_word      (i_last_word),
        .o_done           (o_done),
        .o_maybe_present  (o_maybe_present),
        .o_items_added    (o_items_added),
        .o_bits_set_count (o_bits_set_count)
    );

endmodule

@@ hdl/bfm3_checker.sv @@
// port level checks for the bloom filter core, bound to the top level
module bfm3_sva (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_done
);

    // a result is a single-cycle pulse
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // an accepted word makes the core busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("core not busy after accepting a word");

    // the result comes out as the core returns to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result while still busy");

    // reset starts the store sweep
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> o_busy)
        else $error("core idle right after reset");

endmodule

bind bloom_filter_murmur3_core bfm3_sva u_bfm3_sva (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_done  (o_done)
);
